// File: rtl/rfbe_pkg.sv
// ----------------------------------------------------------------------------
// rfbe_pkg
// shared types and constants of the rgb framebuffer blend engine
// ----------------------------------------------------------------------------
package rfbe_pkg;

   localparam int IN_W    = 18;
   localparam int OUT_W   = 17;
   localparam int REG_W   = 9;
   localparam int COORD_W = 8;
   localparam int CMD_W   = 2;
   localparam int IDX_W   = 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_BLEND = 2'd2,
      CMD_FILL  = 2'd3
   } cmd_type;

   typedef enum logic [IDX_W-1:0] {
      CSR_ACTIVE_WIDTH  = 1'b0,
      CSR_ACTIVE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL  = 4'b0010,
      S_WB   = 4'b0100,
      S_FILL = 4'b1000
   } state_type;

endpackage

// File: rtl/rgb_framebuffer_blend_engine.sv
// ----------------------------------------------------------------------------
// rgb_framebuffer_blend_engine
// rgb pixel store with read, write, alpha blend and fill commands
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; each command gives
// exactly one result, shown for one cycle with rsp_strobe, and the receiver
// cannot hold it off. Pixels live in one single-port-write memory of
// MAX_WIDTH * MAX_HEIGHT words with a registered read port, and every
// in-range read, write or blend is a read, multiply, write-back sequence
// with busy held, so accesses never overlap. Read, write and blend pass
// through memory read, multiply stage and write back before the next
// accept; a command outside the active area, or a fill of an empty area, is
// answered without raising busy. A fill writes one pixel per cycle over
// the active area. No clearing pass is done after reset: pixels must be
// written (usually by a fill) before they are read.
module rgb_framebuffer_blend_engine
   import rfbe_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [CMD_W-1:0]        req_cmd,
   input  logic [COORD_W-1:0]      req_col,
   input  logic [COORD_W-1:0]      req_row,
   input  logic signed [IN_W-1:0]  req_red_in,
   input  logic signed [IN_W-1:0]  req_green_in,
   input  logic signed [IN_W-1:0]  req_blue_in,
   input  logic signed [IN_W-1:0]  req_alpha_in,
   output logic                    rsp_strobe,
   output logic [OUT_W-1:0]        rsp_red_out,
   output logic [OUT_W-1:0]        rsp_green_out,
   output logic [OUT_W-1:0]        rsp_blue_out,
   output logic                    rsp_out_of_range,
   input  logic                    csr_wr_en,
   input  logic [IDX_W-1:0]        csr_index,
   input  logic [REG_W-1:0]        csr_data
);

   localparam int CH_W   = FRAC_BITS + 1;
   localparam int PIX_W  = 3 * CH_W;
   localparam int PROD_W = 2 * CH_W;
   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W  = (CH_W > IN_W - 1) ? CH_W : IN_W - 1;
   localparam logic [CH_W-1:0] ONE = CH_W'(1) << FRAC_BITS;

   function automatic logic [CH_W-1:0] clamp_ch(input logic signed [IN_W-1:0] raw);
      logic [CMP_W-1:0] mag;
      logic [CH_W-1:0]  res;
      mag = CMP_W'(raw[IN_W-2:0]);
      if (raw[IN_W-1]) begin
         res = '0;
      end else if (mag > CMP_W'(ONE)) begin
         res = ONE;
      end else begin
         res = CH_W'(mag);
      end
      return res;
   endfunction

   // control state
   state_type           state_ff, state_in;
   logic [REG_W-1:0]    act_w_ff, act_w_in;
   logic [REG_W-1:0]    act_h_ff, act_h_in;
   logic [REG_W-1:0]    fill_col_ff, fill_col_in;
   logic [REG_W-1:0]    fill_row_ff, fill_row_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   // payload
   logic                rsp_oor_ff, rsp_oor_in;
   logic [CH_W-1:0]     rsp_ch_ff [3];
   logic [CH_W-1:0]     rsp_ch_in [3];
   cmd_type             cmd_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [CH_W-1:0]     clr_ff [3];
   logic [CH_W-1:0]     alpha_ff;
   logic [PROD_W-1:0]   keep_ff [3];
   logic [PROD_W-1:0]   mix_ff [3];
   logic [PIX_W-1:0]    rdata_ff;

   // memory
   logic [PIX_W-1:0]    pix_mem [DEPTH];
   logic                mem_we, mem_re;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [PIX_W-1:0]    mem_wdata;

   logic                accept;
   logic [REG_W-1:0]    eff_w, eff_h;
   logic                oor_now;
   logic [ADDR_W-1:0]   req_addr, fill_addr;
   logic [CH_W-1:0]     clr_req [3];
   logic [CH_W-1:0]     old_ch [3];
   logic [CH_W-1:0]     new_ch [3];
   logic [PROD_W-1:0]   sum_ch [3];
   logic [PIX_W-1:0]    clr_word, new_word;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   assign eff_w = ({23'd0, act_w_ff} < 32'(MAX_WIDTH)) ? act_w_ff : REG_W'(MAX_WIDTH);
   assign eff_h = ({23'd0, act_h_ff} < 32'(MAX_HEIGHT)) ? act_h_ff : REG_W'(MAX_HEIGHT);

   assign oor_now   = ({1'b0, req_col} >= eff_w) || ({1'b0, req_row} >= eff_h);
   assign req_addr  = ADDR_W'(32'(req_row) * 32'(MAX_WIDTH) + 32'(req_col));
   assign fill_addr = ADDR_W'(32'(fill_row_ff) * 32'(MAX_WIDTH) + 32'(fill_col_ff));

   assign clr_req[0] = clamp_ch(req_red_in);
   assign clr_req[1] = clamp_ch(req_green_in);
   assign clr_req[2] = clamp_ch(req_blue_in);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         old_ch[k] = rdata_ff[k*CH_W +: CH_W];
         sum_ch[k] = keep_ff[k] + mix_ff[k];
         case (cmd_ff)
            CMD_WRITE: new_ch[k] = clr_ff[k];
            CMD_BLEND: new_ch[k] = sum_ch[k][FRAC_BITS +: CH_W];
            default:   new_ch[k] = old_ch[k];
         endcase
      end
      clr_word = {clr_ff[2], clr_ff[1], clr_ff[0]};
      new_word = {new_ch[2], new_ch[1], new_ch[0]};
   end

   always_comb begin
      state_in      = state_ff;
      fill_col_in   = fill_col_ff;
      fill_row_in   = fill_row_ff;
      rsp_strobe_in = 1'b0;
      rsp_oor_in    = rsp_oor_ff;
      rsp_ch_in     = rsp_ch_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = addr_ff;
      mem_wdata     = new_word;
      act_w_in      = act_w_ff;
      act_h_in      = act_h_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_ACTIVE_WIDTH:  act_w_in = csr_data;
            CSR_ACTIVE_HEIGHT: act_h_in = csr_data;
            default: ;
         endcase
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (cmd_type'(req_cmd) == CMD_FILL) begin
                  rsp_ch_in  = clr_req;
                  rsp_oor_in = 1'b0;
                  if (eff_w == '0 || eff_h == '0) begin
                     rsp_strobe_in = 1'b1;
                  end else begin
                     fill_col_in = '0;
                     fill_row_in = '0;
                     state_in    = S_FILL;
                  end
               end else if (oor_now) begin
                  rsp_strobe_in = 1'b1;
                  rsp_oor_in    = 1'b1;
                  for (int k = 0; k < 3; k++) begin
                     rsp_ch_in[k] = '0;
                  end
               end else begin
                  mem_re   = 1'b1;
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            state_in = S_WB;
         end
         S_WB: begin
            mem_we        = (cmd_ff != CMD_READ);
            rsp_ch_in     = new_ch;
            rsp_oor_in    = 1'b0;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = fill_addr;
            mem_wdata = clr_word;
            if (fill_col_ff == eff_w - 1'b1) begin
               fill_col_in = '0;
               if (fill_row_ff == eff_h - 1'b1) begin
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  fill_row_in = fill_row_ff + 1'b1;
               end
            end else begin
               fill_col_in = fill_col_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         act_w_ff      <= REG_W'(256);
         act_h_ff      <= REG_W'(256);
         fill_col_ff   <= '0;
         fill_row_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         act_w_ff      <= act_w_in;
         act_h_ff      <= act_h_in;
         fill_col_ff   <= fill_col_in;
         fill_row_ff   <= fill_row_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_oor_ff <= rsp_oor_in;
      rsp_ch_ff  <= rsp_ch_in;
      if (accept) begin
         cmd_ff   <= cmd_type'(req_cmd);
         addr_ff  <= req_addr;
         clr_ff   <= clr_req;
         alpha_ff <= clamp_ch(req_alpha_in);
      end
      if (state_ff == S_MUL) begin
         for (int k = 0; k < 3; k++) begin
            keep_ff[k] <= PROD_W'(ONE - alpha_ff) * PROD_W'(old_ch[k]);
            mix_ff[k]  <= PROD_W'(alpha_ff) * PROD_W'(clr_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pix_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= pix_mem[req_addr];
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_out_of_range = rsp_oor_ff;
   assign rsp_red_out      = OUT_W'(rsp_ch_ff[0]);
   assign rsp_green_out    = OUT_W'(rsp_ch_ff[1]);
   assign rsp_blue_out     = OUT_W'(rsp_ch_ff[2]);

`ifndef SYNTHESIS
   // out-of-range access answers in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (accept && cmd_type'(req_cmd) != CMD_FILL && oor_now)
         |=> (rsp_strobe && rsp_out_of_range))
      else $error("out-of-range item not answered at once");

   // flagged result carries no colour
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_out_of_range)
         |-> (rsp_red_out == '0 && rsp_green_out == '0 && rsp_blue_out == '0))
      else $error("out-of-range result with colour");

   // every busy period ends with its result
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a result");

   // memory writes only in write-back or fill
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_WB || state_ff == S_FILL))
      else $error("memory write outside write-back or fill");
`endif

endmodule

// File: test/rgb_framebuffer_blend_engine_tb.sv
// ----------------------------------------------------------------------------
// rgb_framebuffer_blend_engine_tb
// self-checking bench for the rgb framebuffer blend engine
// ----------------------------------------------------------------------------
// Commands go in one at a time on the start/busy handshake. A frame-store
// model computes the pixel each command should return, and every strobed
// result is checked against it in order. Directed cases cover clamping,
// blend weights at the ends, out-of-range coordinates, an empty area and
// area registers beyond the frame; random traffic then runs under several
// area settings with varying sender gaps.
// ----------------------------------------------------------------------------
module rgb_framebuffer_blend_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rfbe_pkg::*;

   localparam int FRAME_DIM      = 256;
   localparam int ONE            = 65536;
   localparam int BURST_ITEMS    = 133;
   localparam int DRAIN_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 300000;

   typedef struct {
      cmd_type                 cmd;
      logic [COORD_W-1:0]      col;
      logic [COORD_W-1:0]      row;
      logic signed [IN_W-1:0]  red;
      logic signed [IN_W-1:0]  green;
      logic signed [IN_W-1:0]  blue;
      logic signed [IN_W-1:0]  alpha;
   } pixel_cmd_type;

   typedef struct {
      logic [OUT_W-1:0] red;
      logic [OUT_W-1:0] green;
      logic [OUT_W-1:0] blue;
      logic             oor;
   } pixel_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [CMD_W-1:0]       req_cmd = CMD_READ;
   logic [COORD_W-1:0]     req_col = '0;
   logic [COORD_W-1:0]     req_row = '0;
   logic signed [IN_W-1:0] req_red_in = '0;
   logic signed [IN_W-1:0] req_green_in = '0;
   logic signed [IN_W-1:0] req_blue_in = '0;
   logic signed [IN_W-1:0] req_alpha_in = '0;
   logic                   rsp_strobe;
   logic [OUT_W-1:0]       rsp_red_out;
   logic [OUT_W-1:0]       rsp_green_out;
   logic [OUT_W-1:0]       rsp_blue_out;
   logic                   rsp_out_of_range;
   logic                   csr_wr_en = 1'b0;
   logic [IDX_W-1:0]       csr_index = CSR_ACTIVE_WIDTH;
   logic [REG_W-1:0]       csr_data = '0;

   logic [OUT_W-1:0]       frame_mem [0:FRAME_DIM*FRAME_DIM-1][0:2];
   logic [REG_W-1:0]       width_reg = REG_W'(256);
   logic [REG_W-1:0]       height_reg = REG_W'(256);
   pixel_result_type       pending_pixels [$];
   int                     mismatch_count = 0;
   int                     idle_pct = 20;
   int                     quiet_cycles = 0;
   logic [COORD_W-1:0]     last_col = '0;
   logic [COORD_W-1:0]     last_row = '0;

   rgb_framebuffer_blend_engine i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_col          (req_col),
      .req_row          (req_row),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .req_alpha_in     (req_alpha_in),
      .rsp_strobe       (rsp_strobe),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [OUT_W-1:0] clamp_channel(logic signed [IN_W-1:0] v);
      if (v < 0)
         return '0;
      if (v > ONE)
         return OUT_W'(ONE);
      return v[OUT_W-1:0];
   endfunction

   function automatic int unsigned active_cols();
      return (width_reg > FRAME_DIM) ? FRAME_DIM : width_reg;
   endfunction

   function automatic int unsigned active_rows();
      return (height_reg > FRAME_DIM) ? FRAME_DIM : height_reg;
   endfunction

   // updates the frame model and returns the pixel the command reports
   function automatic pixel_result_type apply_pixel_cmd(pixel_cmd_type c);
      logic [OUT_W-1:0] colour [3];
      logic [OUT_W-1:0] res [3];
      logic [OUT_W-1:0] a;
      logic [OUT_W-1:0] old;
      logic [OUT_W-1:0] nv;
      longint unsigned  mix;
      int unsigned      addr;
      pixel_result_type r;
      colour[0] = clamp_channel(c.red);
      colour[1] = clamp_channel(c.green);
      colour[2] = clamp_channel(c.blue);
      a = clamp_channel(c.alpha);
      res = '{default: '0};
      r.oor = 1'b0;
      if (c.cmd == CMD_FILL) begin
         for (int y = 0; y < active_rows(); y++)
            for (int x = 0; x < active_cols(); x++)
               for (int k = 0; k < 3; k++)
                  frame_mem[y*FRAME_DIM+x][k] = colour[k];
         res = colour;
      end else if (c.col >= active_cols() || c.row >= active_rows()) begin
         r.oor = 1'b1;
      end else begin
         addr = c.row * FRAME_DIM + c.col;
         for (int k = 0; k < 3; k++) begin
            old = frame_mem[addr][k];
            case (c.cmd)
               CMD_WRITE: begin
                  nv = colour[k];
               end
               CMD_BLEND: begin
                  mix = (longint'(ONE) - longint'(a)) * longint'(old)
                      + longint'(a) * longint'(colour[k]);
                  nv = OUT_W'(mix >> 16);
               end
               default: begin
                  nv = old;
               end
            endcase
            frame_mem[addr][k] = nv;
            res[k] = nv;
         end
      end
      r.red = res[0];
      r.green = res[1];
      r.blue = res[2];
      return r;
   endfunction

   function automatic pixel_cmd_type make_cmd(cmd_type cmd, int col, int row,
                                              int red, int green, int blue, int alpha);
      pixel_cmd_type c;
      c.cmd = cmd;
      c.col = COORD_W'(col);
      c.row = COORD_W'(row);
      c.red = IN_W'(red);
      c.green = IN_W'(green);
      c.blue = IN_W'(blue);
      c.alpha = IN_W'(alpha);
      return c;
   endfunction

   function automatic logic signed [IN_W-1:0] rand_level();
      int corner_values [7] = '{0, 1, ONE - 1, ONE, ONE + 1, -1, -131072};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            return IN_W'($urandom_range(0, ONE));
         end
         6: begin
            return IN_W'(corner_values[$urandom_range(0, 6)]);
         end
         default: begin
            return IN_W'($urandom);
         end
      endcase
   endfunction

   // mostly chains on the last pixel or hits inside the area, some strays
   function automatic pixel_cmd_type random_pixel_cmd();
      pixel_cmd_type c;
      int unsigned   pick;
      pick = $urandom_range(0, 99);
      if (pick < 3)
         c.cmd = CMD_FILL;
      else if (pick < 33)
         c.cmd = CMD_READ;
      else if (pick < 63)
         c.cmd = CMD_WRITE;
      else
         c.cmd = CMD_BLEND;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         c.col = last_col;
         c.row = last_row;
      end else if (pick < 80 && active_cols() != 0 && active_rows() != 0) begin
         c.col = COORD_W'($urandom_range(0, active_cols() - 1));
         c.row = COORD_W'($urandom_range(0, active_rows() - 1));
      end else begin
         c.col = COORD_W'($urandom);
         c.row = COORD_W'($urandom);
      end
      c.red = rand_level();
      c.green = rand_level();
      c.blue = rand_level();
      c.alpha = rand_level();
      return c;
   endfunction

   task automatic send_item(pixel_cmd_type c);
      if ($urandom_range(1, 100) <= idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= c.cmd;
      req_col <= c.col;
      req_row <= c.row;
      req_red_in <= c.red;
      req_green_in <= c.green;
      req_blue_in <= c.blue;
      req_alpha_in <= c.alpha;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      pending_pixels.push_back(apply_pixel_cmd(c));
      last_col = c.col;
      last_row = c.row;
   endtask

   // called right after the last accept of a burst
   task automatic drain();
      start <= 1'b0;
      while (pending_pixels.size() != 0 || busy !== 1'b0)
         @(posedge clock);
   endtask

   task automatic set_area(int unsigned w, int unsigned h);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ACTIVE_WIDTH;
      csr_data <= REG_W'(w);
      @(posedge clock);
      width_reg = REG_W'(w);
      csr_index <= CSR_ACTIVE_HEIGHT;
      csr_data <= REG_W'(h);
      @(posedge clock);
      height_reg = REG_W'(h);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // whole frame is filled first so every later read hits a written pixel
   task automatic test_full_frame();
      send_item(make_cmd(CMD_FILL, 0, 0, -131072, 131071, 12345, 0));
      send_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0));
      send_item(make_cmd(CMD_READ, 255, 255, -1, -1, -1, -1));
      send_item(make_cmd(CMD_WRITE, 255, 0, ONE, ONE + 1, -1, 0));
      send_item(make_cmd(CMD_WRITE, 0, 255, ONE - 1, 0, 1, 0));
      send_item(make_cmd(CMD_BLEND, 255, 0, 7, 7, 7, 0));
      send_item(make_cmd(CMD_BLEND, 255, 0, 100, 200, 300, ONE));
      send_item(make_cmd(CMD_BLEND, 0, 255, ONE, ONE, ONE, ONE / 2));
      send_item(make_cmd(CMD_BLEND, 0, 255, 500, 500, 500, -5));
      send_item(make_cmd(CMD_BLEND, 128, 128, -7, 40000, 131071, 131071));
      send_item(make_cmd(CMD_READ, 255, 255, 0, 0, 0, 0));
      drain();
   endtask

   task automatic test_out_of_range();
      set_area(3, 5);
      send_item(make_cmd(CMD_FILL, 200, 200, 1000, 2000, 3000, 0));
      send_item(make_cmd(CMD_READ, 2, 4, 0, 0, 0, 0));
      send_item(make_cmd(CMD_READ, 3, 0, 0, 0, 0, 0));
      send_item(make_cmd(CMD_WRITE, 0, 5, 9, 9, 9, 0));
      send_item(make_cmd(CMD_BLEND, 255, 255, 9, 9, 9, ONE));
      send_item(make_cmd(CMD_BLEND, 2, 4, 60000, 60000, 60000, 16384));
      drain();
   endtask

   task automatic test_zero_area();
      set_area(0, 4);
      send_item(make_cmd(CMD_FILL, 0, 0, 9, 99, 999, 0));
      send_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0));
      send_item(make_cmd(CMD_WRITE, 1, 1, 5, 5, 5, 0));
      drain();
   endtask

   task automatic test_oversize_area();
      set_area(511, 1);
      send_item(make_cmd(CMD_FILL, 0, 0, 4242, -3, ONE + 7, 0));
      send_item(make_cmd(CMD_WRITE, 255, 0, 11, 22, 33, 0));
      send_item(make_cmd(CMD_READ, 0, 1, 0, 0, 0, 0));
      send_item(make_cmd(CMD_READ, 255, 0, 0, 0, 0, 0));
      drain();
   endtask

   task automatic test_random_traffic(int pct);
      int unsigned w;
      int unsigned h;
      idle_pct = pct;
      repeat (4) begin
         case ($urandom_range(0, 3))
            0: begin
               w = $urandom_range(1, 24);
               h = $urandom_range(1, 24);
            end
            1: begin
               w = $urandom_range(200, 511);
               h = $urandom_range(1, 3);
            end
            2: begin
               w = $urandom_range(1, 3);
               h = $urandom_range(200, 511);
            end
            default: begin
               w = $urandom_range(0, 511);
               h = $urandom_range(0, 2);
            end
         endcase
         set_area(w, h);
         repeat (BURST_ITEMS) send_item(random_pixel_cmd());
         drain();
      end
   endtask

   task automatic check_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d",
                     $time, rsp_red_out, rsp_green_out, rsp_blue_out, rsp_out_of_range);
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            check_field("red_out", want.red, rsp_red_out);
            check_field("green_out", want.green, rsp_green_out);
            check_field("blue_out", want.blue, rsp_blue_out);
            check_field("out_of_range", OUT_W'(want.oor), OUT_W'(rsp_out_of_range));
         end
      end
   end

   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_full_frame();
      test_out_of_range();
      test_zero_area();
      test_oversize_area();
      test_random_traffic(20);
      test_random_traffic(53);
      test_random_traffic(0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_pixels.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
